// File: hdl/ntg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntg_pkg: shared types and constants of the axis tick generator
// Widths of the internal datapath, the range descriptor carried by the
// queue, the divider request/response and the back-end sequencer states.
// ----------------------------------------------------------------------------
package ntg_pkg;

	localparam int unsigned WORD_W        = 32; // range ends and tick value
	localparam int unsigned NI_W          = 4;  // num_intervals
	localparam int unsigned NI_RESET      = 4;
	localparam int unsigned STEP_OUT_W    = 31; // nice_step port
	localparam int unsigned IDX_W         = 5;  // tick_index port
	localparam int unsigned CNT_W         = 6;  // tick counter, holds 32
	localparam int unsigned RESULT_CAP    = 32;
	localparam int unsigned RAW_W         = 33; // hi - lo and raw step
	localparam int unsigned STEP_W        = 34; // nice step, always < 2^33
	localparam int unsigned CUR_W         = 36; // tick position
	localparam int unsigned SC_W          = 44; // positions scaled by 100
	localparam int unsigned DIV_W         = 35; // divider operand width
	localparam int unsigned DIV_CNT_W     = 6;
	localparam int unsigned HI_CNT        = 27; // candidates 2, 5, 10, 20, ...
	localparam int unsigned LO_CNT        = 30; // candidates 1, .5, .25, .1, ...
	localparam int unsigned CAND_W        = 5;
	localparam int unsigned FIFO_DEPTH    = 2;
	localparam int unsigned MAX_TICKS_DEF = 32;
	localparam int unsigned FRAC_BITS_DEF = 16;

	typedef struct packed {
		logic signed [WORD_W-1:0] lo;
		logic signed [WORD_W-1:0] hi;
		logic [NI_W-1:0]          n;
		logic                     empty; // no interval or hi <= lo
	} range_desc_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIV_W-1:0] quo;
		logic [DIV_W-1:0] rem;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RAW_WAIT,
		ST_SEARCH,
		ST_SUM,
		ST_REM_START,
		ST_REM_WAIT,
		ST_ADJ1,
		ST_ADJ2,
		ST_BOUND,
		ST_SCALE,
		ST_FIRST,
		ST_TICKS,
		ST_EMPTY
	} back_state_t;

	function automatic logic signed [SC_W-1:0] mul100(input logic signed [SC_W-1:0] v);
		return (v <<< 6) + (v <<< 5) + (v <<< 2);
	endfunction

	function automatic logic signed [SC_W-1:0] mul65(input logic signed [SC_W-1:0] v);
		return (v <<< 6) + v;
	endfunction

endpackage

// File: hdl/ntg_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntg_fifo: short descriptor queue
// Register-based FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module ntg_fifo #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] din,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] dout,
	output logic             empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned FILL_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]  mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (fill_q == FILL_W'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

endmodule

// File: hdl/ntg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntg_front: input side of the tick generator
// Holds num_intervals, accepts range transactions, flags the empty cases
// and pushes a descriptor into the queue.
// ----------------------------------------------------------------------------
module ntg_front import ntg_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [NI_W-1:0]          cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [WORD_W-1:0] range_low,
	input  logic signed [WORD_W-1:0] range_high,
	output logic                     push,
	output range_desc_t              desc,
	input  logic                     queue_full
);

	logic [NI_W-1:0] num_intervals_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_intervals_q <= NI_W'(NI_RESET);
		end else if (cfg_we) begin
			num_intervals_q <= cfg_wdata;
		end
	end

	assign in_stall = queue_full;
	assign push     = in_valid && !queue_full;

	always_comb begin
		desc.lo    = range_low;
		desc.hi    = range_high;
		desc.n     = num_intervals_q;
		desc.empty = (num_intervals_q == '0) || (range_high <= range_low);
	end

endmodule

// File: hdl/ntg_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntg_divider: radix-2 restoring divider
// Unsigned quotient and remainder, one bit per cycle; done pulses once the
// last quotient bit is in.
// ----------------------------------------------------------------------------
module ntg_divider import ntg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     quo_q;
	logic [DIV_W-1:0]     dvs_q;
	logic [DIV_W:0]       trial;
	logic [DIV_W:0]       diff;
	logic                 ge;

	assign trial = {rem_q, quo_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ge};
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.quo  = quo_q;
		rsp.rem  = rem_q;
	end

endmodule

// File: hdl/ntg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ntg_back: step rounding and tick emission
// Sequencer that pops a descriptor, divides for the raw step, searches the
// nice-step candidates, places the first tick and streams the ticks out
// through a one-entry output register, or emits a single empty result.
// ----------------------------------------------------------------------------
module ntg_back import ntg_pkg::*; #(
	parameter int unsigned MAX_TICKS = MAX_TICKS_DEF,
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     queue_empty,
	output logic                     pop,
	input  range_desc_t              desc,
	output div_req_t                 div_req,
	input  div_rsp_t                 div_rsp,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [WORD_W-1:0] tick_value,
	output logic [STEP_OUT_W-1:0]    nice_step,
	output logic [IDX_W-1:0]         tick_index,
	output logic                     tick_valid,
	output logic                     last_tick
);

	localparam int unsigned LIMIT = (MAX_TICKS < RESULT_CAP) ? MAX_TICKS : RESULT_CAP;
	localparam logic [RAW_W-1:0] ONE = RAW_W'(1) << FRAC_BITS;

	// candidate tables: above one the step h/2 (3 for h = 5) wins once h << F
	// exceeds the raw step; below one the first m/dec with m << F <= 2*dec*r wins
	logic [63:0]       hi_thr  [HI_CNT];
	logic [STEP_W-1:0] hi_step [HI_CNT];
	logic [RAW_W-1:0]  lo_thr  [LO_CNT];
	logic [STEP_W-1:0] lo_step [LO_CNT];

	for (genvar g = 0; g < HI_CNT; g++) begin : g_hi
		localparam int HK = g / 3;
		localparam int HJ = g % 3;
		localparam logic [63:0] HD = 64'd2 * (64'd10 ** HK);
		localparam logic [63:0] HH = (HJ == 0) ? HD : ((HJ == 1) ? (HD * 5) / 2 : HD * 5);
		localparam logic [63:0] HS = ((HH == 64'd5) ? 64'd6 : HH) << (FRAC_BITS - 1);
		assign hi_thr[g]  = HH << FRAC_BITS;
		assign hi_step[g] = HS[STEP_W-1:0];
	end

	for (genvar g = 0; g < LO_CNT; g++) begin : g_lo
		localparam int LK = g / 3;
		localparam int LJ = g % 3;
		localparam logic [63:0] LM   = (LJ == 0) ? 64'd100 : ((LJ == 1) ? 64'd50 : 64'd25);
		localparam logic [63:0] LDEC = 64'd100 * (64'd10 ** LK);
		localparam logic [63:0] LT   = ((LM << FRAC_BITS) + 2 * LDEC - 1) / (2 * LDEC);
		localparam logic [63:0] LV   = ((LM << FRAC_BITS) + LDEC / 2) / LDEC;
		assign lo_thr[g]  = LT[RAW_W-1:0];
		assign lo_step[g] = LV[STEP_W-1:0];
	end

	back_state_t state_q, state_d;

	range_desc_t              desc_q;
	logic [RAW_W-1:0]         r_q;
	logic [CAND_W-1:0]        cand_q;
	logic [STEP_W-1:0]        step_q;
	logic signed [CUR_W-1:0]  x_q;
	logic signed [CUR_W-1:0]  cur_q;
	logic signed [SC_W-1:0]   p_q;
	logic signed [SC_W-1:0]   q_q;
	logic signed [SC_W-1:0]   b_q;
	logic signed [SC_W-1:0]   step100_q;
	logic signed [SC_W-1:0]   cur100_q;
	logic [CNT_W-1:0]         cnt_q;

	logic                     out_valid_q;
	logic signed [WORD_W-1:0] tick_value_q;
	logic [STEP_OUT_W-1:0]    nice_step_q;
	logic [IDX_W-1:0]         tick_index_q;
	logic                     tick_valid_q;
	logic                     last_tick_q;

	logic                     slot_free;
	logic                     above_one;
	logic                     hit_hi;
	logic                     hit_lo;
	logic                     pick;
	logic                     next_ok;
	logic                     load_tick;
	logic                     load_empty;
	logic [RAW_W-1:0]         span;
	logic signed [CUR_W-1:0]  abs_x;
	logic signed [CUR_W-1:0]  step_c;
	logic signed [CUR_W-1:0]  rem_c;
	logic signed [SC_W-1:0]   sc_step;
	logic signed [SC_W-1:0]   sc_lo;
	logic signed [SC_W-1:0]   sc_hi;
	logic signed [SC_W-1:0]   sc_cur;

	assign slot_free = !out_valid_q || !out_stall;
	assign above_one = (r_q >= ONE);
	assign hit_hi    = (hi_thr[cand_q] > {{(64 - RAW_W){1'b0}}, r_q});
	assign hit_lo    = (r_q >= lo_thr[cand_q]);
	assign pick      = above_one ? (hit_hi || (cand_q == CAND_W'(HI_CNT - 1)))
	                             : (hit_lo || (cand_q == CAND_W'(LO_CNT - 1)));
	assign next_ok   = ((cnt_q + 1'b1) < CNT_W'(LIMIT)) && ((cur100_q + step100_q) < b_q);

	assign span    = {desc_q.hi[WORD_W-1], desc_q.hi} - {desc_q.lo[WORD_W-1], desc_q.lo};
	assign abs_x   = x_q[CUR_W-1] ? -x_q : x_q;
	assign step_c  = {{(CUR_W - STEP_W){1'b0}}, step_q};
	assign rem_c   = {{(CUR_W - STEP_W){1'b0}}, div_rsp.rem[STEP_W-1:0]};
	assign sc_step = {{(SC_W - STEP_W){1'b0}}, step_q};
	assign sc_lo   = {{(SC_W - WORD_W){desc_q.lo[WORD_W-1]}}, desc_q.lo};
	assign sc_hi   = {{(SC_W - WORD_W){desc_q.hi[WORD_W-1]}}, desc_q.hi};
	assign sc_cur  = {{(SC_W - CUR_W){cur_q[CUR_W-1]}}, cur_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		pop              = 1'b0;
		load_tick        = 1'b0;
		load_empty       = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = {{(DIV_W - RAW_W){1'b0}}, span};
		div_req.divisor  = {{(DIV_W - NI_W){1'b0}}, desc_q.n};
		if (state_q == ST_REM_START) begin
			div_req.dividend = abs_x[DIV_W-1:0];
			div_req.divisor  = {{(DIV_W - STEP_W){1'b0}}, step_q};
		end
		case (state_q)
			ST_IDLE: begin
				if (!queue_empty) begin
					pop     = 1'b1;
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (desc_q.empty) begin
					state_d = ST_EMPTY;
				end else begin
					div_req.start = 1'b1;
					state_d       = ST_RAW_WAIT;
				end
			end
			ST_RAW_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (pick) begin
					state_d = ST_SUM;
				end
			end
			ST_SUM:       state_d = ST_REM_START;
			ST_REM_START: begin
				div_req.start = 1'b1;
				state_d       = ST_REM_WAIT;
			end
			ST_REM_WAIT: begin
				if (div_rsp.done) begin
					state_d = ST_ADJ1;
				end
			end
			ST_ADJ1:  state_d = ST_ADJ2;
			ST_ADJ2:  state_d = ST_BOUND;
			ST_BOUND: state_d = ST_SCALE;
			ST_SCALE: state_d = ST_FIRST;
			ST_FIRST: begin
				state_d = (cur100_q < b_q) ? ST_TICKS : ST_EMPTY;
			end
			ST_TICKS: begin
				if (slot_free) begin
					load_tick = 1'b1;
					if (!next_ok) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EMPTY: begin
				if (slot_free) begin
					load_empty = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					desc_q <= desc;
				end
			end
			ST_RAW_WAIT: begin
				if (div_rsp.done) begin
					// a raw step below one LSB counts as one LSB
					r_q    <= (div_rsp.quo == '0) ? RAW_W'(1) : div_rsp.quo[RAW_W-1:0];
					cand_q <= '0;
				end
			end
			ST_SEARCH: begin
				if (pick) begin
					step_q <= above_one ? hi_step[cand_q] : lo_step[cand_q];
				end else begin
					cand_q <= cand_q + 1'b1;
				end
			end
			ST_SUM: begin
				x_q <= step_c + {{(CUR_W - WORD_W){desc_q.lo[WORD_W-1]}}, desc_q.lo};
			end
			ST_REM_WAIT: begin
				// x minus its truncating remainder: step * trunc(x / step)
				if (div_rsp.done) begin
					cur_q <= x_q[CUR_W-1] ? x_q + rem_c : x_q - rem_c;
				end
			end
			ST_ADJ1: begin
				p_q <= mul100(sc_cur - sc_lo);
				q_q <= mul65(sc_step);
			end
			ST_ADJ2: begin
				if (p_q < q_q) begin
					cur_q <= cur_q + step_c;
				end
			end
			ST_BOUND: begin
				b_q       <= mul100(sc_hi) - q_q;
				step100_q <= mul100(sc_step);
			end
			ST_SCALE: begin
				cur100_q <= mul100(sc_cur);
				cnt_q    <= '0;
			end
			ST_TICKS: begin
				if (slot_free) begin
					cur_q    <= cur_q + step_c;
					cur100_q <= cur100_q + step100_q;
					cnt_q    <= cnt_q + 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_tick || load_empty) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_tick) begin
			tick_value_q <= cur_q[WORD_W-1:0];
			nice_step_q  <= (|step_q[STEP_W-1:STEP_OUT_W]) ? '1 : step_q[STEP_OUT_W-1:0];
			tick_index_q <= cnt_q[IDX_W-1:0];
			tick_valid_q <= 1'b1;
			last_tick_q  <= !next_ok;
		end else if (load_empty) begin
			tick_value_q <= '0;
			nice_step_q  <= '0;
			tick_index_q <= '0;
			tick_valid_q <= 1'b0;
			last_tick_q  <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign tick_value = tick_value_q;
	assign nice_step  = nice_step_q;
	assign tick_index = tick_index_q;
	assign tick_valid = tick_valid_q;
	assign last_tick  = last_tick_q;

endmodule

// File: hdl/nice_axis_tick_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nice_axis_tick_generator_top: axis tick generator
// Turns a Q(32-FRAC_BITS).FRAC_BITS value range into evenly spaced ticks at
// a rounded step.
// ----------------------------------------------------------------------------
// One range transaction yields a run of tick results, the last one flagged
// by last_tick, or a single result with tick_valid low when the range is
// empty, num_intervals is zero or no tick fits. Once a range leaves the
// queue, the raw-step division, the step candidate search, the first-tick
// remainder division (both divisions on one shared radix-2 divider) and the
// adjust, bound and scale steps come before its first tick is on the
// output; then one tick per cycle follows when the output is not stalled.
// Up to two further ranges are queued while a run is in progress.
// num_intervals (reset 4) is written through cfg_we/cfg_wdata; the user
// must write it only while the block is idle, which the block itself does
// not enforce.
// ----------------------------------------------------------------------------
module nice_axis_tick_generator_top import ntg_pkg::*; #(
	parameter int unsigned MAX_TICKS = MAX_TICKS_DEF,
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [NI_W-1:0]          cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [WORD_W-1:0] range_low,
	input  logic signed [WORD_W-1:0] range_high,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [WORD_W-1:0] tick_value,
	output logic [STEP_OUT_W-1:0]    nice_step,
	output logic [IDX_W-1:0]         tick_index,
	output logic                     tick_valid,
	output logic                     last_tick
);

	logic        push;
	logic        pop;
	logic        queue_full;
	logic        queue_empty;
	range_desc_t desc_in;
	range_desc_t desc_out;
	div_req_t    div_req;
	div_rsp_t    div_rsp;

	ntg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.range_low  (range_low),
		.range_high (range_high),
		.push       (push),
		.desc       (desc_in),
		.queue_full (queue_full)
	);

	ntg_fifo #(
		.WIDTH ($bits(range_desc_t)),
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (desc_in),
		.full   (queue_full),
		.pop    (pop),
		.dout   (desc_out),
		.empty  (queue_empty)
	);

	ntg_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	ntg_back #(
		.MAX_TICKS (MAX_TICKS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.pop         (pop),
		.desc        (desc_out),
		.div_req     (div_req),
		.div_rsp     (div_rsp),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.tick_value  (tick_value),
		.nice_step   (nice_step),
		.tick_index  (tick_index),
		.tick_valid  (tick_valid),
		.last_tick   (last_tick)
	);

endmodule
